/* rtl/replay_filter_sorted_set_macros.svh */
// Assertion macros shared by the replay filter RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef REPLAY_FILTER_SORTED_SET_MACROS_SVH
`define REPLAY_FILTER_SORTED_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RFSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rfss assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RFSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rfss assertion failed");

`endif

/* rtl/rfss_pkg.sv */
// Package for the replay filter: identifier width and compare result type.
// No dependencies; used by rfss_cmp and replay_filter_sorted_set.
`default_nettype none

package rfss_pkg;

    localparam int ID_W = 64;

    // Result of one magnitude compare of operand a against operand b
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

`default_nettype wire

/* rtl/replay_filter_sorted_set.sv */
// Replay filter top level: sequencer over a sorted id table in rfss_ram, one shared rfss_cmp.
// Per item: watermark check, then a scan of S entries (S = 0 for a zero id, a watermark hit
// or an empty table, else up to CAPACITY); a placed insert also shifts up to CAPACITY-1 table
// entries and writes the new id. One item at a time: in_ready stays low until the result is
// loaded, and a held result stalls that.
// Reset clears fill count, watermark and handshake state; the table needs no clearing pass.
`default_nettype none

module replay_filter_sorted_set #(
    parameter int CAPACITY = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      action,
    input  wire logic [rfss_pkg::ID_W-1:0] ident,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           answer,
    output logic                           evicted
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WM    = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_UP_RD = 4'd4;
    localparam logic [3:0] S_UP_WR = 4'd5;
    localparam logic [3:0] S_DN_RD = 4'd6;
    localparam logic [3:0] S_DN_WR = 4'd7;
    localparam logic [3:0] S_PUT   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]                state_reg,   state_next;
    logic                      act_reg,     act_next;
    logic [rfss_pkg::ID_W-1:0] id_reg,      id_next;
    logic [CW-1:0]             idx_reg,     idx_next;
    logic [CW-1:0]             pos_reg,     pos_next;
    logic [CW-1:0]             fill_reg,    fill_next;
    logic [rfss_pkg::ID_W-1:0] wm_reg,      wm_next;
    logic [rfss_pkg::ID_W-1:0] min_reg,     min_next;
    logic                      res_ans_reg, res_ans_next;
    logic                      ev_reg,      ev_next;
    logic                      ovalid_reg,  ovalid_next;
    logic                      oans_reg,    oans_next;
    logic                      oev_reg,     oev_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [rfss_pkg::ID_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [rfss_pkg::ID_W-1:0] ram_rdata;

    logic [rfss_pkg::ID_W-1:0] cmp_a;
    rfss_pkg::cmp_t            cmp_res;

    logic [CW-1:0]             idx_inc;
    logic [CW-1:0]             idx_dec;
    logic [CW-1:0]             scan_pos;
    logic [CW-1:0]             scan_pos_dec;
    logic [rfss_pkg::ID_W-1:0] scan_min;
    logic                      full;

    rfss_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (rfss_pkg::ID_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Share one compare unit between the watermark check and the scan
    assign cmp_a = (state_reg == S_WM) ? wm_reg : ram_rdata;

    rfss_cmp u_cmp (
        .a   (cmp_a),
        .b   (id_reg),
        .res (cmp_res)
    );

    assign idx_inc      = idx_reg + CW'(1);
    assign idx_dec      = idx_reg - CW'(1);
    assign scan_pos     = cmp_res.lt ? idx_inc : idx_reg;
    assign scan_pos_dec = scan_pos - CW'(1);
    assign scan_min     = (idx_reg == '0) ? ram_rdata : min_reg;
    assign full         = (fill_reg == CW'(CAPACITY));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign answer    = oans_reg;
    assign evicted   = oev_reg;

    // Sequence watermark check, scan, table shift and placement
    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        wm_next      = wm_reg;
        min_next     = min_reg;
        res_ans_next = res_ans_reg;
        ev_next      = ev_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        oans_next    = oans_reg;
        oev_next     = oev_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[AW-1:0];
        ram_wdata    = id_reg;
        ram_raddr    = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action;
                    id_next      = ident;
                    ev_next      = 1'b0;
                    res_ans_next = 1'b0;
                    state_next   = S_WM;
                end
            end
            S_WM:
            begin
                idx_next = '0;
                if (id_reg == '0)
                begin
                    res_ans_next = 1'b0;
                    state_next   = S_EMIT;
                end
                else if (!cmp_res.lt)
                begin
                    // At or below the watermark: known
                    res_ans_next = !act_reg;
                    state_next   = S_EMIT;
                end
                else if (fill_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = act_reg ? S_PUT : S_EMIT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    min_next = ram_rdata;
                end
                if (cmp_res.eq)
                begin
                    res_ans_next = !act_reg;
                    state_next   = S_EMIT;
                end
                else if (cmp_res.lt && (idx_inc != fill_reg))
                begin
                    idx_next   = idx_inc;
                    state_next = S_RD;
                end
                else if (!act_reg)
                begin
                    state_next = S_EMIT;
                end
                else if (full)
                begin
                    if (scan_pos == '0)
                    begin
                        // Below the smallest entry of a full table: reject
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        // Retire the smallest entry, then shift down
                        wm_next    = scan_min;
                        ev_next    = 1'b1;
                        idx_next   = '0;
                        pos_next   = scan_pos_dec;
                        state_next = (scan_pos_dec == '0) ? S_PUT : S_DN_RD;
                    end
                end
                else
                begin
                    pos_next   = scan_pos;
                    idx_next   = fill_reg;
                    state_next = (scan_pos == fill_reg) ? S_PUT : S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                ram_raddr  = idx_dec[AW-1:0];
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = (idx_dec == pos_reg) ? S_PUT : S_UP_RD;
            end
            S_DN_RD:
            begin
                ram_raddr  = idx_inc[AW-1:0];
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = (idx_inc == pos_reg) ? S_PUT : S_DN_RD;
            end
            S_PUT:
            begin
                ram_we       = 1'b1;
                ram_waddr    = pos_reg[AW-1:0];
                res_ans_next = 1'b1;
                if (!ev_reg)
                begin
                    fill_next = fill_reg + CW'(1);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hand the result over once the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oans_next   = res_ans_reg;
                    oev_next    = ev_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the output transfer flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            wm_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            wm_reg     <= wm_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        id_reg      <= id_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        min_reg     <= min_next;
        res_ans_reg <= res_ans_next;
        ev_reg      <= ev_next;
        oans_reg    <= oans_next;
        oev_reg     <= oev_next;
    end

`include "replay_filter_sorted_set_macros.svh"

    `RFSS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CW'(CAPACITY))
    `RFSS_ASSERT_NEXT(a_fill_step, clk, rst_n, 1'b1, CW'(fill_reg - $past(fill_reg)) <= CW'(1))
    `RFSS_ASSERT_IMP(a_evict_accepts, clk, rst_n, out_valid && evicted, answer)
    `RFSS_ASSERT_IMP(a_write_on_insert, clk, rst_n, ram_we, act_reg)
    `RFSS_ASSERT_NEXT(a_start_check, clk, rst_n, in_valid && in_ready, state_reg == S_WM)

endmodule

`default_nettype wire

/* rtl/rfss_cmp.sv */
// Shared 64-bit unsigned compare unit of the replay filter.
// Depends on rfss_pkg for the identifier width and result struct.
`default_nettype none

module rfss_cmp (
    input  wire logic [rfss_pkg::ID_W-1:0] a,
    input  wire logic [rfss_pkg::ID_W-1:0] b,
    output rfss_pkg::cmp_t                 res
);

    // Compare a against b
    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

`default_nettype wire

/* rtl/rfss_ram.sv */
// Single-write, single-read table memory with registered read data.
// Holds the sorted identifier table; no package dependencies.
`default_nettype none

module rfss_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write one entry and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
